@@ design/tfn_pkg.sv @@
// Package for the triangle face normal unit: request, status and command codes
// and the command word passed from the front end to the back end.
// No dependencies.
`default_nettype none
package tfn_pkg;

  localparam int TFN_VERTEX_DEPTH = 4096;
  // index fields in the command word; covers every store depth up to 65536
  localparam int IDX_W = 16;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_TRI    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] CMD_STAT   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TRI    = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [IDX_W-1:0] ia;    // corner a, or store address of an append
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [95:0]      vtx;   // {z, y, x}
  } cmd_t;

endpackage
`default_nettype wire

@@ design/triangle_face_normal_unit.sv @@
// Triangle face normal unit, top level: front end, command queue, back end.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
//
// Input words (in_*) carry a request kind in in_tuser: append a vertex, ask
// for the normal of a triangle, or clear the vertex store. Every word gives
// exactly one result word on out_*, in request order: the Q1.15 unit normal
// of (c-b) x (a-b) and a status (ok, index out of range, degenerate, full).
// Appends, clears and rejected requests pass through the queue and the output
// register before out_tvalid rises, and wait while a triangle is in the back
// end. A triangle goes through the back end as three memory reads, six passes
// through one 32x32 multiplier, a one bit a cycle normalising shift, a 31 step
// square root and three 17 step divides; a degenerate one skips to the result.
// Triangles are handled one at a time; the front end keeps accepting into a
// two word queue meanwhile. Reset empties the store count and drops queued
// words; the store memory itself is not cleared. When the receiver holds off
// out_tready the result waits in the output register, the queue fills and
// in_tready falls.
`default_nettype none
module triangle_face_normal_unit #(
  parameter int VERTEX_DEPTH = tfn_pkg::TFN_VERTEX_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [135:0] in_tdata,   // coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, pad
  input  wire  [1:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [47:0]  out_tdata,  // normal_x, normal_y, normal_z
  output logic [1:0]   out_tuser   // status
);
  import tfn_pkg::*;

  localparam int CW = $clog2(VERTEX_DEPTH + 1);

  logic          push, q_full, q_valid, pop;
  cmd_t          f_cmd, q_cmd;
  logic [CW-1:0] count;
  logic [15:0]   nx, ny, nz;

  tfn_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .req_type (in_tuser),
    .coord_x  (in_tdata[31:0]),
    .coord_y  (in_tdata[63:32]),
    .coord_z  (in_tdata[95:64]),
    .corner_a (in_tdata[107:96]),
    .corner_b (in_tdata[119:108]),
    .corner_c (in_tdata[131:120]),
    .q_full   (q_full),
    .push     (push),
    .cmd      (f_cmd),
    .count    (count)
  );

  tfn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_cmd),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_cmd)
  );

  tfn_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .normal_x  (nx),
    .normal_y  (ny),
    .normal_z  (nz),
    .status    (out_tuser)
  );

  assign out_tdata = {nz, ny, nx};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count) <= VERTEX_DEPTH)
    else $error("vertex count beyond store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_CLEAR) |=> count == '0)
    else $error("clear did not empty the store");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("non-zero normal with failing status");

endmodule
`default_nettype wire

@@ design/tfn_front.sv @@
// Front end: takes request words, keeps the vertex count, checks indices and
// store space and turns each request into a command. Depends on tfn_pkg.
`default_nettype none
module tfn_front #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [1:0]                           req_type,
  input  wire  [31:0]                          coord_x,
  input  wire  [31:0]                          coord_y,
  input  wire  [31:0]                          coord_z,
  input  wire  [11:0]                          corner_a,
  input  wire  [11:0]                          corner_b,
  input  wire  [11:0]                          corner_c,
  input  wire                                  q_full,
  output logic                                 push,
  output tfn_pkg::cmd_t                        cmd,
  output logic [$clog2(VERTEX_DEPTH+1)-1:0]    count
);
  import tfn_pkg::*;

  localparam int CW = $clog2(VERTEX_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          bad_idx;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign count    = count_r;

  assign bad_idx = (32'(corner_a) >= 32'(count_r)) || (32'(corner_b) >= 32'(count_r)) ||
                   (32'(corner_c) >= 32'(count_r));

  always_comb begin
    count_nxt  = count_r;
    cmd.kind   = CMD_STAT;
    cmd.status = ST_OK;
    cmd.ia     = IDX_W'(corner_a);
    cmd.ib     = IDX_W'(corner_b);
    cmd.ic     = IDX_W'(corner_c);
    cmd.vtx    = {coord_z, coord_y, coord_x};
    unique case (req_type)
      REQ_APPEND: begin
        if (count_r == CW'(VERTEX_DEPTH)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind  = CMD_APPEND;
          cmd.ia    = IDX_W'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_TRI: begin
        if (bad_idx) cmd.status = ST_RANGE;
        else cmd.kind = CMD_TRI;
      end
      REQ_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/tfn_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on tfn_pkg.
`default_nettype none
module tfn_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  tfn_pkg::cmd_t push_data,
  output logic          full,
  input  wire           pop,
  output logic          valid,
  output tfn_pkg::cmd_t pop_data
);
  import tfn_pkg::*;

  cmd_t       ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/tfn_back.sv @@
// Back end: vertex memory, cross product with a shared 32x32 multiplier,
// normalising shifts, bit-serial square root and divide, result register.
// Depends on tfn_pkg.
`default_nettype none
module tfn_back #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           q_valid,
  input  tfn_pkg::cmd_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  wire           out_ready,
  output logic [15:0]   normal_x,
  output logic [15:0]   normal_y,
  output logic [15:0]   normal_z,
  output logic [1:0]    status
);
  import tfn_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  localparam logic [4:0] S_IDLE = 5'd0,  S_RD0 = 5'd1,  S_RD1 = 5'd2,  S_RD2 = 5'd3;
  localparam logic [4:0] S_RD3  = 5'd4,  S_MUL = 5'd5,  S_ACC = 5'd6,  S_MAG = 5'd7;
  localparam logic [4:0] S_MAX  = 5'd8,  S_SHR = 5'd9,  S_SHL = 5'd10, S_SQ  = 5'd11;
  localparam logic [4:0] S_SQRT = 5'd12, S_DLD = 5'd13, S_DIV = 5'd14, S_OUT = 5'd15;

  logic [4:0]   state_r;
  logic [95:0]  mem [VERTEX_DEPTH];
  logic [95:0]  rd_data_r, pb_r, vc_r;
  logic [AW-1:0] ia_r, ib_r, ic_r, rd_addr;
  logic signed [32:0] u_r [3];
  logic signed [32:0] v_r [3];
  logic [2:0]   step_r;
  logic [63:0]  prod_r;
  logic         pneg_r;
  logic signed [66:0] cr_r [3];
  logic [65:0]  mag_r [3];
  logic         neg_r [3];
  logic [65:0]  mx_r;
  logic [61:0]  sum_r, sv_r, sres_r;
  logic [60:0]  sbit_r;
  logic [31:0]  norm_r;
  logic [16:0]  num_r, quo_r;
  logic [32:0]  rem_r;
  logic [4:0]   cnt_r;
  logic [1:0]   comp_r;
  logic [15:0]  nrm_r [3];
  logic [1:0]   st_r;
  logic         out_valid_r;
  logic [15:0]  onx_r, ony_r, onz_r;
  logic [1:0]   ost_r;

  logic         out_free, wr_en, emit_stat, emit_res;
  logic signed [32:0] opa, opb;
  logic [32:0]  ma, mb;
  logic signed [66:0] sp;
  logic [65:0]  m01, mx;
  logic [29:0]  sq_op;
  logic [59:0]  sq;
  logic [61:0]  st_t, sres_n;
  logic [46:0]  num47;
  logic [33:0]  rem2, dvs;
  logic         ge;
  logic [16:0]  qf, qs;
  logic [15:0]  qv;

  assign out_free  = !out_valid_r || out_ready;
  assign emit_stat = (state_r == S_IDLE) && q_valid && (q_data.kind != CMD_TRI) && out_free;
  assign emit_res  = (state_r == S_OUT) && out_free;
  assign wr_en     = emit_stat && (q_data.kind == CMD_APPEND);
  assign pop       = (state_r == S_IDLE) && q_valid && ((q_data.kind == CMD_TRI) || out_free);

  assign out_valid = out_valid_r;
  assign normal_x  = onx_r;
  assign normal_y  = ony_r;
  assign normal_z  = onz_r;
  assign status    = ost_r;

  always_comb begin
    unique case (state_r)
      S_RD0:   rd_addr = ib_r;
      S_RD1:   rd_addr = ic_r;
      default: rd_addr = ia_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_data.ia[AW-1:0]] <= q_data.vtx;
    rd_data_r <= mem[rd_addr];
  end

  // operand pairs of the cross product, two products per component
  always_comb begin
    unique case (step_r)
      3'd0:    begin opa = u_r[1]; opb = v_r[2]; end
      3'd1:    begin opa = u_r[2]; opb = v_r[1]; end
      3'd2:    begin opa = u_r[2]; opb = v_r[0]; end
      3'd3:    begin opa = u_r[0]; opb = v_r[2]; end
      3'd4:    begin opa = u_r[0]; opb = v_r[1]; end
      default: begin opa = u_r[1]; opb = v_r[0]; end
    endcase
    ma = opa[32] ? 33'(-opa) : 33'(opa);
    mb = opb[32] ? 33'(-opb) : 33'(opb);
    sp = pneg_r ? -$signed({3'b000, prod_r}) : $signed({3'b000, prod_r});
    m01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    mx  = (m01 > mag_r[2]) ? m01 : mag_r[2];
    sq_op = mag_r[step_r[1:0]][29:0];
    sq    = sq_op * sq_op;
    st_t  = sres_r + 62'(sbit_r);
    sres_n = (sv_r >= st_t) ? (sres_r >> 1) + 62'(sbit_r) : (sres_r >> 1);
    num47 = {1'b0, mag_r[comp_r][29:0], 16'h0000} + 47'(norm_r);
    rem2  = {rem_r, num_r[16]};
    dvs   = {1'b0, norm_r, 1'b0};
    ge    = (rem2 >= dvs);
    qf    = {quo_r[15:0], ge};
    if (neg_r[comp_r]) begin
      qs = (qf > 17'd32768) ? 17'd32768 : qf;
      qv = 16'(-qs);
    end else begin
      qs = qf;
      qv = (qf > 17'd32767) ? 16'h7FFF : qf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ia_r <= q_data.ia[AW-1:0];
        ib_r <= q_data.ib[AW-1:0];
        ic_r <= q_data.ic[AW-1:0];
      end
      S_RD1: pb_r <= rd_data_r;
      S_RD2: vc_r <= rd_data_r;
      S_RD3: begin
        for (int k = 0; k < 3; k++) begin
          u_r[k] <= 33'($signed(vc_r[32*k +: 32])) - 33'($signed(pb_r[32*k +: 32]));
          v_r[k] <= 33'($signed(rd_data_r[32*k +: 32])) - 33'($signed(pb_r[32*k +: 32]));
        end
        step_r <= '0;
      end
      S_MUL: begin
        prod_r <= ma[31:0] * mb[31:0];
        pneg_r <= opa[32] ^ opb[32];
      end
      S_ACC: begin
        if (!step_r[0]) cr_r[step_r[2:1]] <= sp;
        else cr_r[step_r[2:1]] <= cr_r[step_r[2:1]] - sp;
        step_r <= step_r + 3'd1;
      end
      S_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= cr_r[k][66];
          mag_r[k] <= cr_r[k][66] ? 66'(-cr_r[k]) : cr_r[k][65:0];
        end
      end
      S_MAX: begin
        mx_r <= mx;
        for (int k = 0; k < 3; k++) nrm_r[k] <= '0;
        st_r <= ST_DEGEN;
      end
      S_SHR: begin
        if (|mx_r[65:30]) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          mx_r <= mx_r >> 1;
        end
      end
      S_SHL: begin
        if (!mx_r[29]) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          mx_r <= mx_r << 1;
        end
        step_r <= '0;
        sum_r  <= '0;
      end
      S_SQ: begin
        sum_r  <= sum_r + 62'(sq);
        sv_r   <= sum_r + 62'(sq);
        sres_r <= '0;
        sbit_r <= 61'(1) << 60;
        step_r <= step_r + 3'd1;
      end
      S_SQRT: begin
        if (sv_r >= st_t) sv_r <= sv_r - st_t;
        sres_r <= sres_n;
        sbit_r <= sbit_r >> 2;
        norm_r <= sres_n[31:0];
        comp_r <= '0;
      end
      S_DLD: begin
        // the quotient stays below 2^17, so the top bits start the remainder
        rem_r <= 33'(num47[46:17]);
        num_r <= num47[16:0];
        quo_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= ge ? rem2[32:0] - dvs[32:0] : rem2[32:0];
        quo_r <= qf;
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          nrm_r[comp_r] <= qv;
          comp_r <= comp_r + 2'd1;
          st_r <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (pop && (q_data.kind == CMD_TRI)) state_r <= S_RD0;
        S_RD0:  state_r <= S_RD1;
        S_RD1:  state_r <= S_RD2;
        S_RD2:  state_r <= S_RD3;
        S_RD3:  state_r <= S_MUL;
        S_MUL:  state_r <= S_ACC;
        S_ACC:  state_r <= (step_r == 3'd5) ? S_MAG : S_MUL;
        S_MAG:  state_r <= S_MAX;
        S_MAX:  state_r <= (mx == '0) ? S_OUT : S_SHR;
        S_SHR:  if (!(|mx_r[65:30])) state_r <= S_SHL;
        S_SHL:  if (mx_r[29]) state_r <= S_SQ;
        S_SQ:   if (step_r == 3'd2) state_r <= S_SQRT;
        S_SQRT: if (sbit_r[0]) state_r <= S_DLD;
        S_DLD:  state_r <= S_DIV;
        S_DIV:  if (cnt_r == 5'd16) state_r <= (comp_r == 2'd2) ? S_OUT : S_DLD;
        S_OUT:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_stat || emit_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_stat) begin
      onx_r <= '0;
      ony_r <= '0;
      onz_r <= '0;
      ost_r <= q_data.status;
    end else if (emit_res) begin
      onx_r <= nrm_r[0];
      ony_r <= nrm_r[1];
      onz_r <= nrm_r[2];
      ost_r <= st_r;
    end
  end

endmodule
`default_nettype wire
